@@ sv/fvn_pkg.sv @@
package fvn_pkg;

    localparam int PERSIST_W    = 17;
    localparam int OCT_W        = 4;
    localparam int CFG_DATA_W   = 17;
    localparam int COORD_W      = 32;
    localparam int NOISE_W      = 25;
    localparam int VAL_W        = 37;
    localparam int SUM_W        = 56;
    localparam int LANE_LAT     = 12;
    localparam int SUM_LAT      = 4;
    localparam int RESULT_LAT   = LANE_LAT + SUM_LAT + 1;

    localparam logic [PERSIST_W-1:0] PERSIST_RESET = 17'd32768;
    localparam logic [PERSIST_W-1:0] PERSIST_MAX   = 17'd65536;
    localparam logic [OCT_W-1:0]     OCT_RESET     = 4'd4;
    localparam logic [16:0]          AMP_ONE       = 17'd65536;

    localparam logic [31:0] HASH_Y     = 32'd57;
    localparam int          HASH_SHIFT = 13;
    localparam logic [31:0] HASH_A     = 32'd15731;
    localparam logic [31:0] HASH_B     = 32'd789221;
    localparam logic [31:0] HASH_C     = 32'd1376312589;
    localparam logic [31:0] Q30_ONE    = 32'h4000_0000;

    localparam longint OUT_MAX   = 64'sd8388608;
    localparam longint PI_Q30    = 64'sd3373259426;
    localparam longint Q30_ONE_L = 64'sd1073741824;
    localparam longint COS_DIV [12] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552};

    typedef enum logic {
        CFG_PERSISTENCE  = 1'b0,
        CFG_OCTAVE_COUNT = 1'b1
    } t_cfg_idx;

    // (1 - cos(pi*k/2^bits)) / 2 in Q1.16, Horner series for cos in Q30
    function automatic logic [16:0] cos_entry(int k, int bits);
        longint full;
        longint half;
        longint kk;
        longint x;
        longint x2;
        longint acc;
        longint t;
        longint e;
        full = 64'sd1 <<< bits;
        half = full >>> 1;
        kk   = (longint'(k) <= half) ? longint'(k) : full - longint'(k);
        x    = (PI_Q30 * kk + (64'sd1 <<< (bits - 1))) >>> bits;
        x2   = (x * x + (64'sd1 <<< 29)) >>> 30;
        acc  = Q30_ONE_L;
        for (int n = 12; n >= 1; n--) begin
            t   = ((x2 * acc + (64'sd1 <<< 29)) >>> 30) / COS_DIV[n-1];
            acc = Q30_ONE_L - t;
            if (acc < 0) acc = 0;
            if (acc > Q30_ONE_L) acc = Q30_ONE_L;
        end
        e = (Q30_ONE_L - acc + (64'sd1 <<< 14)) >>> 15;
        if (longint'(k) > half) e = 64'sd65536 - e;
        return 17'(e);
    endfunction

endpackage

@@ sv/fractal_value_noise_2d.sv @@
// Fractal 2D value noise: one Q16.16 point in, one Q4.20 sample out.
// Request channel: a point on i_coord_x/i_coord_y is taken at a rising edge
// where start is high and busy is low. busy is low whenever reset is
// released, so a new request can be issued every cycle.
// Result channel: o_valid is high for exactly one cycle with o_noise_value;
// the receiver cannot stall it.
// Pipeline: input register, 12 octave stages, 4 weighting/sum stages.
// Throughput: one request per cycle; every octave has its own lane with its
// own cosine table and hash multipliers, and the octave amplitudes are
// built one multiply per stage alongside the data.
// Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 persistence, 1 octave count) at the clock edge; write only while idle.
// Reset: synchronous, active low; clears the valid line and restores
// persistence 0.5 and four octaves. Requests in flight are dropped.
module fractal_value_noise_2d #(
    parameter int MAX_OCTAVES    = 8,
    parameter int FRACTION_BITS  = 16,
    parameter int COS_TABLE_BITS = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [fvn_pkg::COORD_W-1:0]     i_coord_x,
    input  logic signed [fvn_pkg::COORD_W-1:0]     i_coord_y,
    input  logic                                   i_cfg_we,
    input  logic [0:0]                             i_cfg_idx,
    input  logic [fvn_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    output logic                                   o_valid,
    output logic signed [fvn_pkg::NOISE_W-1:0]     o_noise_value
);

    localparam int CNT_W = $clog2(MAX_OCTAVES + 1);
    localparam int LAT   = fvn_pkg::LANE_LAT;

    logic [fvn_pkg::PERSIST_W-1:0] r_persistence;
    logic [fvn_pkg::OCT_W-1:0]     r_octave_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_persistence  <= fvn_pkg::PERSIST_RESET;
            r_octave_count <= fvn_pkg::OCT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fvn_pkg::CFG_PERSISTENCE:  r_persistence  <= i_cfg_data;
                fvn_pkg::CFG_OCTAVE_COUNT: r_octave_count <= i_cfg_data[fvn_pkg::OCT_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = !i_rst_n;

    logic                 accept;
    logic                 r_v0;
    logic signed [31:0]   r_x, r_y;
    logic [16:0]          r_p, n_p;
    logic [CNT_W-1:0]     r_cnt, n_cnt;

    assign accept = start && !busy;
    assign n_p    = (r_persistence > fvn_pkg::PERSIST_MAX) ? fvn_pkg::PERSIST_MAX
                                                           : r_persistence;
    assign n_cnt  = (int'(r_octave_count) > MAX_OCTAVES) ? CNT_W'(MAX_OCTAVES)
                                                         : CNT_W'(r_octave_count);

    always_ff @(posedge i_clk) begin
        r_x   <= i_coord_x;
        r_y   <= i_coord_y;
        r_p   <= n_p;
        r_cnt <= n_cnt;
    end

    logic [LAT-1:0]            r_vpipe;
    logic [LAT-1:0][CNT_W-1:0] r_cpipe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_vpipe <= '0;
        end else begin
            r_v0    <= accept;
            r_vpipe <= {r_vpipe[LAT-2:0], r_v0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cpipe <= {r_cpipe[LAT-2:0], r_cnt};
    end

    logic [MAX_OCTAVES-1:0][fvn_pkg::VAL_W-1:0] lane_val;
    logic [MAX_OCTAVES-1:0][16:0]               amp;

    for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
        fvn_lane #(
            .OCT            (i),
            .FRACTION_BITS  (FRACTION_BITS),
            .COS_TABLE_BITS (COS_TABLE_BITS)
        ) u_lane (
            .i_clk (i_clk),
            .i_x   (r_x),
            .i_y   (r_y),
            .o_val (lane_val[i])
        );
    end

    fvn_amp #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_amp (
        .i_clk (i_clk),
        .i_p   (r_p),
        .o_amp (amp)
    );

    fvn_sum #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_sum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (r_vpipe[LAT-1]),
        .i_cnt         (r_cpipe[LAT-1]),
        .i_val         (lane_val),
        .i_amp         (amp),
        .o_valid       (o_valid),
        .o_noise_value (o_noise_value)
    );

endmodule

@@ sv/fvn_lane.sv @@
module fvn_lane #(
    parameter int OCT            = 0,
    parameter int FRACTION_BITS  = 16,
    parameter int COS_TABLE_BITS = 10
) (
    input  logic                             i_clk,
    input  logic signed [31:0]               i_x,
    input  logic signed [31:0]               i_y,
    output logic        [fvn_pkg::VAL_W-1:0] o_val
);

    localparam int FB    = FRACTION_BITS;
    localparam int MW    = 32 + OCT;
    localparam int IW    = COS_TABLE_BITS + 1;
    localparam int ROM_N = (1 << COS_TABLE_BITS) + 1;
    localparam int SH    = FRACTION_BITS - COS_TABLE_BITS;
    localparam int VW    = fvn_pkg::VAL_W;
    localparam int DW    = VW + 1;
    localparam int PW    = fvn_pkg::SUM_W;

    logic [16:0] cos_rom [ROM_N];

    for (genvar k = 0; k < ROM_N; k++) begin : g_rom
        localparam logic [16:0] ENTRY = fvn_pkg::cos_entry(k, COS_TABLE_BITS);
        assign cos_rom[k] = ENTRY;
    end

    // stage 1: lattice cell and table index
    logic [31:0]    ax, ay, ipx, ipy;
    logic [MW-1:0]  mag_x, mag_y;
    logic [FB-1:0]  fmx, fmy;
    logic [IW-1:0]  ix, iy;
    logic [31:0]    n_cx1, n_cy1;
    logic [31:0]    r_cx1, r_cy1;
    logic [IW-1:0]  r_ix1, r_iy1;

    always_comb begin
        ax    = i_x[31] ? 32'(-i_x) : 32'(i_x);
        ay    = i_y[31] ? 32'(-i_y) : 32'(i_y);
        mag_x = MW'(ax) << OCT;
        mag_y = MW'(ay) << OCT;
        ipx   = 32'(mag_x >> FB);
        ipy   = 32'(mag_y >> FB);
        fmx   = mag_x[FB-1:0];
        fmy   = mag_y[FB-1:0];
        n_cx1 = i_x[31] ? 32'(-ipx) : ipx;
        n_cy1 = i_y[31] ? 32'(-ipy) : ipy;
    end

    // rounded index never exceeds 2^COS_TABLE_BITS
    if (SH > 0) begin : g_idx_rnd
        localparam int RS = (SH > 0) ? SH - 1 : 0;
        assign ix = IW'(({1'b0, fmx} + (FB + 1)'(1 << RS)) >> SH);
        assign iy = IW'(({1'b0, fmy} + (FB + 1)'(1 << RS)) >> SH);
    end else begin : g_idx_lsh
        localparam int LS = -SH;
        assign ix = IW'(fmx) << LS;
        assign iy = IW'(fmy) << LS;
    end

    always_ff @(posedge i_clk) begin
        r_cx1 <= n_cx1;
        r_cy1 <= n_cy1;
        r_ix1 <= ix;
        r_iy1 <= iy;
    end

    // stage 2: weights from table, hash seed for the 4x4 lattice patch
    logic [16:0]       r_fx2, r_fy2;
    logic [15:0][31:0] n_h2, r_h2;

    always_comb begin
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] nn;
        for (int gy = 0; gy < 4; gy++) begin
            for (int gx = 0; gx < 4; gx++) begin
                px = r_cx1 + 32'(gx - 1);
                py = r_cy1 + 32'(gy - 1);
                nn = px + py * fvn_pkg::HASH_Y;
                n_h2[gy*4+gx] = (nn << fvn_pkg::HASH_SHIFT) ^ nn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fx2 <= cos_rom[r_ix1];
        r_fy2 <= cos_rom[r_iy1];
        r_h2  <= n_h2;
    end

    // stages 3..5: hash polynomial, one multiply per stage
    logic [15:0][31:0]        r_m3, r_h3, r_m4, r_h4;
    logic [15:0][31:0]        n_lv5;
    logic signed [31:0]       r_lv5 [16];

    always_comb begin
        logic [31:0] t;
        for (int k = 0; k < 16; k++) begin
            t = r_h4[k] * r_m4[k] + fvn_pkg::HASH_C;
            n_lv5[k] = fvn_pkg::Q30_ONE - {1'b0, t[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 16; k++) begin
            r_m3[k]  <= r_h2[k] * r_h2[k];
            r_h3[k]  <= r_h2[k];
            r_m4[k]  <= r_m3[k] * fvn_pkg::HASH_A + fvn_pkg::HASH_B;
            r_h4[k]  <= r_h3[k];
            r_lv5[k] <= $signed(n_lv5[k]);
        end
    end

    // stage 6: 3x3 smoothing of the four cell corners
    logic signed [VW-1:0] n_s6 [4];
    logic signed [VW-1:0] r_s6 [4];

    always_comb begin
        logic signed [VW-1:0] cr;
        logic signed [VW-1:0] sd;
        logic signed [VW-1:0] ct;
        for (int sy = 0; sy < 2; sy++) begin
            for (int sx = 0; sx < 2; sx++) begin
                cr = VW'(r_lv5[sy*4+sx]) + VW'(r_lv5[sy*4+sx+2])
                   + VW'(r_lv5[(sy+2)*4+sx]) + VW'(r_lv5[(sy+2)*4+sx+2]);
                sd = VW'(r_lv5[(sy+1)*4+sx]) + VW'(r_lv5[(sy+1)*4+sx+2])
                   + VW'(r_lv5[sy*4+sx+1]) + VW'(r_lv5[(sy+2)*4+sx+1]);
                ct = VW'(r_lv5[(sy+1)*4+sx+1]);
                n_s6[sy*2+sx] = cr + (sd <<< 1) + (ct <<< 2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) r_s6[k] <= n_s6[k];
    end

    // weight delay lines
    logic [16:0] r_fxd [5];
    logic [16:0] r_fyd [8];

    always_ff @(posedge i_clk) begin
        r_fxd[0] <= r_fx2;
        for (int k = 1; k < 5; k++) r_fxd[k] <= r_fxd[k-1];
        r_fyd[0] <= r_fy2;
        for (int k = 1; k < 8; k++) r_fyd[k] <= r_fyd[k-1];
    end

    // stages 7..9: horizontal blend, top row and bottom row
    logic signed [VW-1:0] r_a7 [2];
    logic signed [DW-1:0] r_d7 [2];
    logic signed [VW-1:0] r_a8 [2];
    logic signed [PW-1:0] r_p8 [2];
    logic signed [VW-1:0] r_b9 [2];
    logic signed [PW-1:0] n_b9 [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_b9[k] = ((PW'(r_a8[k]) <<< 16) + r_p8[k] + PW'(32768)) >>> 16;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            r_a7[k] <= r_s6[2*k];
            r_d7[k] <= DW'(r_s6[2*k+1]) - DW'(r_s6[2*k]);
            r_a8[k] <= r_a7[k];
            r_p8[k] <= PW'(r_d7[k] * $signed({1'b0, r_fxd[4]}));
            r_b9[k] <= VW'(n_b9[k]);
        end
    end

    // stages 10..12: vertical blend
    logic signed [VW-1:0] r_t10, r_t11, r_val12;
    logic signed [DW-1:0] r_d10;
    logic signed [PW-1:0] r_p11;
    logic signed [PW-1:0] n_val12;

    assign n_val12 = ((PW'(r_t11) <<< 16) + r_p11 + PW'(32768)) >>> 16;

    always_ff @(posedge i_clk) begin
        r_t10   <= r_b9[0];
        r_d10   <= DW'(r_b9[1]) - DW'(r_b9[0]);
        r_t11   <= r_t10;
        r_p11   <= PW'(r_d10 * $signed({1'b0, r_fyd[7]}));
        r_val12 <= VW'(n_val12);
    end

    assign o_val = r_val12;

endmodule

@@ sv/fvn_amp.sv @@
module fvn_amp #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                        i_clk,
    input  logic [16:0]                 i_p,
    output logic [MAX_OCTAVES-1:0][16:0] o_amp
);

    localparam int LAT = fvn_pkg::LANE_LAT;

    logic [LAT-1:0][MAX_OCTAVES-1:0][16:0] n_amp, r_amp;
    logic [LAT-2:0][16:0]                  r_pd;

    // stage j appends amp[j+1] = round(amp[j] * p / 2^16)
    always_comb begin
        logic [16:0] prev;
        logic [16:0] pin;
        logic [33:0] prod;
        for (int j = 0; j < LAT; j++) begin
            pin = (j == 0) ? i_p : r_pd[(j == 0) ? 0 : j - 1];
            for (int i = 0; i < MAX_OCTAVES; i++) begin
                if (j == 0) begin
                    prev = (i == 0) ? fvn_pkg::AMP_ONE : 17'd0;
                end else begin
                    prev = r_amp[j-1][i];
                end
                n_amp[j][i] = prev;
                if (i == j + 1) begin
                    if (j == 0) begin
                        prod = 34'(fvn_pkg::AMP_ONE) * 34'(pin) + 34'd32768;
                    end else begin
                        prod = 34'(r_amp[j-1][j]) * 34'(pin) + 34'd32768;
                    end
                    n_amp[j][i] = 17'(prod >> 16);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_amp   <= n_amp;
        r_pd[0] <= i_p;
        for (int j = 1; j < LAT - 1; j++) r_pd[j] <= r_pd[j-1];
    end

    assign o_amp = r_amp[LAT-1];

endmodule

@@ sv/fvn_sum.sv @@
module fvn_sum #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_vld,
    input  logic [$clog2(MAX_OCTAVES+1)-1:0]            i_cnt,
    input  logic [MAX_OCTAVES-1:0][fvn_pkg::VAL_W-1:0]  i_val,
    input  logic [MAX_OCTAVES-1:0][16:0]                i_amp,
    output logic                                        o_valid,
    output logic signed [fvn_pkg::NOISE_W-1:0]          o_noise_value
);

    localparam int SW = fvn_pkg::SUM_W;
    localparam int NG = (MAX_OCTAVES + 3) / 4;

    logic                          r_v1, r_v2, r_v3, r_valid;
    logic [MAX_OCTAVES-1:0][SW-1:0] n_prod, r_prod;
    logic [NG-1:0][SW-1:0]          n_grp, r_grp;
    logic signed [SW-1:0]           n_tot, r_tot;
    logic signed [SW-1:0]           rnd;
    logic signed [fvn_pkg::NOISE_W-1:0] n_out, r_out;

    always_comb begin
        logic signed [fvn_pkg::VAL_W+17:0] pr;
        for (int i = 0; i < MAX_OCTAVES; i++) begin
            pr = $signed(i_val[i]) * $signed({1'b0, i_amp[i]});
            n_prod[i] = (i < int'(i_cnt)) ? SW'(pr) : '0;
        end
    end

    always_comb begin
        logic signed [SW-1:0] acc;
        for (int g = 0; g < NG; g++) begin
            acc = '0;
            for (int k = 0; k < 4; k++) begin
                if (g * 4 + k < MAX_OCTAVES) acc = acc + $signed(r_prod[g*4+k]);
            end
            n_grp[g] = acc;
        end
        n_tot = '0;
        for (int g = 0; g < NG; g++) n_tot = n_tot + $signed(r_grp[g]);
    end

    always_comb begin
        rnd = (r_tot + SW'(64'sd536870912)) >>> 30;
        if (rnd > SW'(fvn_pkg::OUT_MAX)) begin
            n_out = fvn_pkg::NOISE_W'(fvn_pkg::OUT_MAX);
        end else if (rnd < -SW'(fvn_pkg::OUT_MAX)) begin
            n_out = fvn_pkg::NOISE_W'(-fvn_pkg::OUT_MAX);
        end else begin
            n_out = fvn_pkg::NOISE_W'(rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_grp  <= n_grp;
        r_tot  <= n_tot;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v1    <= i_vld;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_valid <= r_v3;
        end
    end

    assign o_valid       = r_valid;
    assign o_noise_value = r_out;

endmodule

@@ sv/fvn_checker.sv @@
module fvn_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_valid,
    input logic signed [fvn_pkg::NOISE_W-1:0] o_noise_value
);

    // every request yields one result after the fixed latency
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(fvn_pkg::RESULT_LAT) o_valid)
        else $error("request without result");

    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, fvn_pkg::RESULT_LAT))
        else $error("result without request");

    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_noise_value <= 25'sd8388608 && o_noise_value >= -25'sd8388608))
        else $error("noise value outside saturation range");

endmodule

bind fractal_value_noise_2d fvn_checker u_fvn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_noise_value (o_noise_value)
);
